/* src/esfd_pkg.sv */
// ----------------------------------------------------------------------------
// esfd_pkg
// Shared types, constants and lookup functions for the encoder speed filter
// and display core.
// ----------------------------------------------------------------------------
package esfd_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int DPOS_W      = (NUM_DIGITS > 4) ? 3 : 2;

    localparam int SCALE_W     = 10;
    localparam int COEF_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int ACC_W       = 40;
    localparam int MAG_W       = 16;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 56;

    localparam int DIV10_MULT  = 52429;
    localparam int DIV10_SHIFT = 19;

    function automatic int pow10(input int n);
        int r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    localparam int MAG_LIMIT   = pow10(NUM_DIGITS) - 1;
    localparam int MAG_MAX     = (MAG_LIMIT > 32768) ? 32768 : MAG_LIMIT;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_SCALE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POLE_COEF   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_COEF   = 2'd2;

    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 10'd30;
    localparam logic [COEF_W-1:0]  POLE_COEF_RST   = 16'd63512;
    localparam logic [COEF_W-1:0]  GAIN_COEF_RST   = 16'd2027;

    typedef logic signed [SPEED_W-1:0] speed_t;

    typedef struct packed {
        logic [SCALE_W-1:0] speed_scale;
        logic [COEF_W-1:0]  pole_coef;
        logic [COEF_W-1:0]  gain_coef;
    } cfg_t;

    typedef struct packed {
        logic   push;
        speed_t raw;
    } fifo_wr_t;

    typedef struct packed {
        logic   valid;
        speed_t raw;
    } fifo_rd_t;

    typedef struct packed {
        logic        polarity_led;
        logic [7:0]  segments;
        logic [7:0]  digit_enable;
        logic [1:0]  digit_index;
        speed_t      filtered_speed;
        speed_t      raw_speed;
    } result_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] digit_select(input logic [DPOS_W-1:0] k);
        return ~(8'h20 >> k);
    endfunction

endpackage

/* src/esfd_front.sv */
// ----------------------------------------------------------------------------
// esfd_front
// Input stage: counts encoder edges with saturation and, on a sample tick,
// scales the count to rpm and queues it for the filter.
// ----------------------------------------------------------------------------
module esfd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [esfd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic [esfd_pkg::SCALE_W-1:0]  speed_scale,
    input  logic                          fifo_full,
    output esfd_pkg::fifo_wr_t            fifo_wr
);
    import esfd_pkg::*;

    localparam int PROD_W = SPEED_W + SCALE_W + 1;

    logic signed [SPEED_W-1:0] count_reg;
    logic signed [SPEED_W-1:0] count_next;
    logic signed [PROD_W-1:0]  prod;
    speed_t                    raw_next;
    logic                      accept;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;

    assign prod = count_reg * $signed({1'b0, speed_scale});

    always_comb begin
        if (prod > PROD_W'(32767)) begin
            raw_next = 16'sh7FFF;
        end else if (prod < -PROD_W'(32768)) begin
            raw_next = 16'sh8000;
        end else begin
            raw_next = prod[SPEED_W-1:0];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_tuser == CMD_TICK) begin
                count_next = '0;
            end else if (s_tdata[0]) begin
                if (count_reg != 16'sh8000) begin
                    count_next = count_reg - 16'sd1;
                end
            end else begin
                if (count_reg != 16'sh7FFF) begin
                    count_next = count_reg + 16'sd1;
                end
            end
        end
    end

    assign fifo_wr.push = accept && (s_tuser == CMD_TICK);
    assign fifo_wr.raw  = raw_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

/* src/esfd_fifo.sv */
// ----------------------------------------------------------------------------
// esfd_fifo
// Short queue of raw speed samples between the front and the filter.
// ----------------------------------------------------------------------------
module esfd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  esfd_pkg::fifo_wr_t wr,
    output logic               full,
    input  logic               pop,
    output esfd_pkg::fifo_rd_t rd
);
    import esfd_pkg::*;

    speed_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign rd.valid = (cnt_reg != '0);
    assign rd.raw   = mem_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && rd.valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr.raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

/* src/esfd_back.sv */
// ----------------------------------------------------------------------------
// esfd_back
// Filter and display sequencer: runs the Q16 low-pass filter as a sequence
// of registered steps, extracts the selected decimal digit and holds the result.
// ----------------------------------------------------------------------------
module esfd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  esfd_pkg::cfg_t     cfg,
    input  esfd_pkg::fifo_rd_t rd,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output esfd_pkg::result_t  result
);
    import esfd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_PSUM,
        ST_FBACK,
        ST_ACCUM,
        ST_SCALE,
        ST_MAG,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    localparam logic signed [41:0] SUM_MAX = 42'sh007F_FFFF_FFFF;
    localparam logic signed [41:0] SUM_MIN = -42'sh0080_0000_0000;

    state_t                   state_reg;
    speed_t                   raw_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [39:0]              pl_reg;
    logic signed [32:0]       ph_reg;
    logic signed [32:0]       gx_reg;
    logic signed [56:0]       p_reg;
    logic signed [40:0]       fb_reg;
    speed_t                   filt_reg;
    logic [MAG_W-1:0]         v_reg;
    logic [MAG_W-1:0]         q_reg;
    logic [DPOS_W-1:0]        steps_reg;
    logic [DPOS_W-1:0]        dpos_reg;
    logic                     m_tvalid_reg;
    result_t                  result_reg;

    logic [39:0]              pl_next;
    logic signed [32:0]       ph_next;
    logic signed [32:0]       gx_next;
    logic signed [32:0]       pole_s;
    logic signed [32:0]       gain_s;
    logic signed [32:0]       ah_s;
    logic signed [32:0]       raw_s;
    logic signed [56:0]       p_next;
    logic signed [56:0]       p_adj;
    logic signed [40:0]       fb_next;
    logic signed [41:0]       sum;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  a_adj;
    logic signed [23:0]       q24;
    speed_t                   filt_next;
    logic [16:0]              fx;
    logic [16:0]              mag;
    logic [MAG_W-1:0]         v_next;
    logic [31:0]              div_prod;
    logic [MAG_W-1:0]         div_next;
    logic [MAG_W-1:0]         digit_wide;
    logic [DPOS_W-1:0]        dpos_next;
    logic                     out_free;

    assign pole_s = {17'b0, cfg.pole_coef};
    assign gain_s = {17'b0, cfg.gain_coef};
    assign ah_s   = {{17{acc_reg[39]}}, acc_reg[39:24]};
    assign raw_s  = {{17{raw_reg[15]}}, raw_reg};

    assign pl_next = 40'(cfg.pole_coef) * 40'(acc_reg[23:0]);
    assign ph_next = pole_s * ah_s;
    assign gx_next = gain_s * raw_s;

    assign p_next  = $signed({ph_reg, 24'b0}) + $signed({17'b0, pl_reg});
    assign p_adj   = p_reg + (p_reg[56] ? 57'sd65535 : 57'sd0);
    assign fb_next = p_adj[56:16];

    assign sum = {fb_reg[40], fb_reg} + {{9{gx_reg[32]}}, gx_reg};

    always_comb begin
        if (sum > SUM_MAX) begin
            acc_next = SUM_MAX[ACC_W-1:0];
        end else if (sum < SUM_MIN) begin
            acc_next = SUM_MIN[ACC_W-1:0];
        end else begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    assign a_adj = acc_reg + (acc_reg[39] ? 40'sd65535 : 40'sd0);
    assign q24   = a_adj[39:16];

    always_comb begin
        if (q24 > 24'sd32767) begin
            filt_next = 16'sh7FFF;
        end else if (q24 < -24'sd32768) begin
            filt_next = 16'sh8000;
        end else begin
            filt_next = q24[15:0];
        end
    end

    assign fx  = {filt_reg[15], filt_reg};
    assign mag = fx[16] ? (17'd0 - fx) : fx;

    always_comb begin
        if (mag > 17'(MAG_MAX)) begin
            v_next = MAG_W'(MAG_MAX);
        end else begin
            v_next = mag[MAG_W-1:0];
        end
    end

    assign div_prod   = 32'(v_reg) * 32'(DIV10_MULT);
    assign div_next   = MAG_W'(div_prod >> DIV10_SHIFT);
    assign digit_wide = v_reg - (q_reg << 3) - (q_reg << 1);

    always_comb begin
        if (dpos_reg == DPOS_W'(NUM_DIGITS - 1)) begin
            dpos_next = '0;
        end else begin
            dpos_next = dpos_reg + 1'b1;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && rd.valid;
    assign m_tvalid = m_tvalid_reg;
    assign result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            dpos_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (rd.valid) begin
                        raw_reg   <= rd.raw;
                        state_reg <= ST_MULT;
                    end
                end
                ST_MULT: begin
                    pl_reg    <= pl_next;
                    ph_reg    <= ph_next;
                    gx_reg    <= gx_next;
                    state_reg <= ST_PSUM;
                end
                ST_PSUM: begin
                    p_reg     <= p_next;
                    state_reg <= ST_FBACK;
                end
                ST_FBACK: begin
                    fb_reg    <= fb_next;
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    acc_reg   <= acc_next;
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    filt_reg  <= filt_next;
                    state_reg <= ST_MAG;
                end
                ST_MAG: begin
                    v_reg     <= v_next;
                    steps_reg <= DPOS_W'(NUM_DIGITS - 1) - dpos_reg;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (steps_reg == '0) begin
                        q_reg     <= div_next;
                        state_reg <= ST_DONE;
                    end else begin
                        v_reg     <= div_next;
                        steps_reg <= steps_reg - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        result_reg.raw_speed      <= raw_reg;
                        result_reg.filtered_speed <= filt_reg;
                        result_reg.digit_index    <= dpos_reg[1:0];
                        result_reg.digit_enable   <= digit_select(dpos_reg);
                        result_reg.segments       <= seg_pattern(digit_wide[3:0]);
                        result_reg.polarity_led   <= !filt_reg[15];
                        m_tvalid_reg              <= 1'b1;
                        dpos_reg                  <= dpos_next;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/encoder_speed_filter_display_core.sv */
// ----------------------------------------------------------------------------
// encoder_speed_filter_display_core
// Quadrature encoder tachometer with Q16 low-pass filter and a multiplexed
// seven-segment speed display.
// ----------------------------------------------------------------------------
// Encoder edges (tuser 0) are accepted back to back while the queue is not full.
// A sample tick (tuser 1) is scaled to rpm at the input and placed in a
// four-entry queue; the filter and display sequencer then takes it through
// its multiply chain (MULT, PSUM, FBACK, ACCUM), SCALE, MAG and a
// divide-by-ten loop whose length depends on the selected digit position,
// then DONE. The input stalls only while the queue holds four ticks. Each
// tick gives one result; edges give none.
// ----------------------------------------------------------------------------
module encoder_speed_filter_display_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [esfd_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [esfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [esfd_pkg::S_TDATA_W-1:0]      s_tdata,  // [0] phase_b
    input  logic                                s_tuser,  // [0] command
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] raw_speed, [31:16] filtered_speed, [33:32] digit_index,
    // [41:34] digit_enable, [49:42] segments, [50] polarity_led
    output logic [esfd_pkg::M_TDATA_W-1:0]      m_tdata
);
    import esfd_pkg::*;

    cfg_t     cfg_reg;
    fifo_wr_t fifo_wr;
    fifo_rd_t fifo_rd;
    logic     fifo_full;
    logic     fifo_pop;
    result_t  result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_scale <= SPEED_SCALE_RST;
            cfg_reg.pole_coef   <= POLE_COEF_RST;
            cfg_reg.gain_coef   <= GAIN_COEF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SPEED_SCALE: cfg_reg.speed_scale <= cfg_wdata[SCALE_W-1:0];
                CFG_POLE_COEF:   cfg_reg.pole_coef   <= cfg_wdata[COEF_W-1:0];
                CFG_GAIN_COEF:   cfg_reg.gain_coef   <= cfg_wdata[COEF_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    esfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .speed_scale (cfg_reg.speed_scale),
        .fifo_full   (fifo_full),
        .fifo_wr     (fifo_wr)
    );

    esfd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (fifo_wr),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .rd      (fifo_rd)
    );

    esfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .rd       (fifo_rd),
        .pop      (fifo_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {5'b0, result.polarity_led, result.segments, result.digit_enable,
                      result.digit_index, result.filtered_speed, result.raw_speed};

endmodule

/* tb/tb_encoder_speed_filter_display_core.sv */
// ----------------------------------------------------------------------------
// tb_encoder_speed_filter_display_core
// Self-checking bench for the encoder speed filter and display core.
// The bench drives encoder edges and sample ticks with random input gaps and
// random output stalls. It predicts every display result from its own
// tachometer and filter model and compares the results field by field.
// ----------------------------------------------------------------------------
module tb_encoder_speed_filter_display_core;
    import esfd_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int PRINT_MAX       = 40;
    localparam int IDLE_PCT        = 7;
    localparam int RES_W           = $bits(result_t);

    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam longint ACC_TOP    = (longint'(1) <<< 39) - 1;
    localparam longint ACC_BOTTOM = -(longint'(1) <<< 39);

    // digit 9 in the top byte down to digit 0 in the bottom byte
    localparam logic [79:0] SEG_ROM = {
        8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = CMD_EDGE;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // tachometer model state and register copies
    int                     count_m;
    longint                 acc_m;
    int                     pos_m;
    logic [SCALE_W-1:0]     scale_m;
    logic [COEF_W-1:0]      pole_m;
    logic [COEF_W-1:0]      gain_m;

    result_t                pending_readings[$];
    result_t                seen_reading;
    result_t                due_reading;
    int                     mismatches  = 0;
    int                     cycle_count = 0;
    bit                     free_flow   = 1'b0;

    encoder_speed_filter_display_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= free_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        if (mismatches < PRINT_MAX) begin
            $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got_v, want_v);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("result with no tick outstanding",
                                longint'(m_tdata[RES_W-1:0]), 0);
            end else begin
                due_reading  = pending_readings.pop_front();
                seen_reading = result_t'(m_tdata[RES_W-1:0]);
                if (seen_reading.raw_speed != due_reading.raw_speed)
                    report_mismatch("raw_speed", longint'(seen_reading.raw_speed),
                                    longint'(due_reading.raw_speed));
                if (seen_reading.filtered_speed != due_reading.filtered_speed)
                    report_mismatch("filtered_speed", longint'(seen_reading.filtered_speed),
                                    longint'(due_reading.filtered_speed));
                if (seen_reading.digit_index != due_reading.digit_index)
                    report_mismatch("digit_index", longint'(seen_reading.digit_index),
                                    longint'(due_reading.digit_index));
                if (seen_reading.digit_enable != due_reading.digit_enable)
                    report_mismatch("digit_enable", longint'(seen_reading.digit_enable),
                                    longint'(due_reading.digit_enable));
                if (seen_reading.segments != due_reading.segments)
                    report_mismatch("segments", longint'(seen_reading.segments),
                                    longint'(due_reading.segments));
                if (seen_reading.polarity_led != due_reading.polarity_led)
                    report_mismatch("polarity_led", longint'(seen_reading.polarity_led),
                                    longint'(due_reading.polarity_led));
                if (m_tdata[M_TDATA_W-1:RES_W] != '0)
                    report_mismatch("tdata padding",
                                    longint'(m_tdata[M_TDATA_W-1:RES_W]), 0);
            end
        end
    end

    function automatic int clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    task automatic tach_reset();
        count_m = 0;
        acc_m   = 0;
        pos_m   = 0;
        scale_m = SPEED_SCALE_RST;
        pole_m  = POLE_COEF_RST;
        gain_m  = GAIN_COEF_RST;
    endtask

    // advance the tachometer by one accepted transfer and, for a tick, queue its reading
    task automatic tach_step(input logic cmd, input logic phb);
        int      raw;
        int      filt;
        int      mag;
        int      place;
        int      top;
        longint  nxt;
        result_t r;
        if (cmd == CMD_EDGE) begin
            if (phb) begin
                if (count_m > -32768) count_m--;
            end else begin
                if (count_m < 32767) count_m++;
            end
        end else begin
            raw     = clamp16(longint'(count_m) * longint'(scale_m));
            count_m = 0;
            nxt     = (longint'(pole_m) * acc_m) / 65536 + longint'(gain_m) * longint'(raw);
            if (nxt > ACC_TOP) nxt = ACC_TOP;
            if (nxt < ACC_BOTTOM) nxt = ACC_BOTTOM;
            acc_m   = nxt;
            filt    = clamp16(acc_m / 65536);
            mag     = (filt < 0) ? -filt : filt;
            top     = 1;
            for (int i = 0; i < NUM_DIGITS; i++) top *= 10;
            if (mag > top - 1) mag = top - 1;
            place   = 1;
            for (int i = pos_m + 1; i < NUM_DIGITS; i++) place *= 10;
            r.raw_speed      = raw[SPEED_W-1:0];
            r.filtered_speed = filt[SPEED_W-1:0];
            r.digit_index    = pos_m[1:0];
            r.digit_enable   = 8'hFF ^ (8'h20 >> pos_m);
            r.segments       = SEG_ROM[8 * ((mag / place) % 10) +: 8];
            r.polarity_led   = (filt >= 0);
            pending_readings.push_back(r);
            pos_m = (pos_m + 1 >= NUM_DIGITS) ? 0 : pos_m + 1;
        end
    endtask

    task automatic send_event(input logic cmd, input logic phb);
        while (!free_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, phb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tach_step(cmd, phb);
    endtask

    // hold the input until every pending reading is out, then let edges settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_SPEED_SCALE: scale_m = val[SCALE_W-1:0];
            CFG_POLE_COEF:   pole_m  = val;
            CFG_GAIN_COEF:   gain_m  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] scale_v,
                              input logic [CFG_DATA_W-1:0] pole_v,
                              input logic [CFG_DATA_W-1:0] gain_v);
        drain_results();
        write_reg(CFG_SPEED_SCALE, scale_v);
        write_reg(CFG_POLE_COEF, pole_v);
        write_reg(CFG_GAIN_COEF, gain_v);
    endtask

    task automatic send_edges(input int n, input logic phb);
        repeat (n) send_event(CMD_EDGE, phb);
    endtask

    task automatic test_reset_state();
        send_event(CMD_TICK, 1'b0);
        send_edges(5, 1'b0);
        send_event(CMD_TICK, 1'b1);
        send_edges(9, 1'b1);
        send_event(CMD_TICK, 1'b0);
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_TICK, 1'b0);
    endtask

    task automatic test_register_masking();
        set_config(16'hFFFF, 16'd0, 16'hFFFF);
        write_reg(CFG_UNMAPPED, 16'h0005);
        send_edges(40, 1'b0);
        send_event(CMD_TICK, 1'b0);
        send_edges(40, 1'b1);
        send_event(CMD_TICK, 1'b1);
        send_event(CMD_TICK, 1'b0);
        drain_results();
        write_reg(CFG_SPEED_SCALE, 16'd0);
        send_edges(5, 1'b0);
        send_event(CMD_TICK, 1'b0);
    endtask

    task automatic test_count_limits();
        set_config(16'd1023, POLE_COEF_RST, GAIN_COEF_RST);
        send_edges(50, 1'b0);
        send_event(CMD_TICK, 1'b0);
        send_edges(50, 1'b1);
        send_event(CMD_TICK, 1'b1);
    endtask

    task automatic test_accumulator_limits();
        set_config(16'd1023, 16'hFFFF, 16'hFFFF);
        repeat (2) begin
            send_edges(33, 1'b0);
            send_event(CMD_TICK, 1'b0);
        end
        drain_results();
        write_reg(CFG_POLE_COEF, 16'd0);
        send_event(CMD_TICK, 1'b1);
        drain_results();
        write_reg(CFG_POLE_COEF, 16'hFFFF);
        repeat (2) begin
            send_edges(33, 1'b1);
            send_event(CMD_TICK, 1'b1);
        end
    endtask

    task automatic run_traffic(input int n_items);
        int sent;
        int burst;
        int rise_pct;
        sent = 0;
        while (sent < n_items) begin
            burst    = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
            rise_pct = ($urandom_range(2) == 0) ? 5 : (($urandom_range(1) == 0) ? 50 : 95);
            repeat (burst) begin
                send_event(CMD_EDGE, $urandom_range(99) >= rise_pct);
                sent++;
            end
            send_event(CMD_TICK, 1'($urandom_range(1)));
            sent++;
        end
    endtask

    task automatic test_random_traffic();
        set_config(16'(SPEED_SCALE_RST), POLE_COEF_RST, GAIN_COEF_RST);
        run_traffic(80);
        set_config(16'd1023, 16'hFFFF, 16'hFFFF);
        free_flow = 1'b1;
        run_traffic(80);
        free_flow = 1'b0;
        set_config(16'd0, 16'd0, 16'd0);
        run_traffic(40);
        repeat (4) begin
            set_config(16'($urandom_range(1023)),
                       ($urandom_range(1) == 0) ? 16'($urandom_range(65535, 60000))
                                                : 16'($urandom_range(65535)),
                       16'($urandom_range(65535)));
            run_traffic(20);
            drain_results();
            run_traffic(20);
        end
    endtask

    initial begin
        tach_reset();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_register_masking();
        test_count_limits();
        test_accumulator_limits();
        test_random_traffic();
        drain_results();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
